// ----- hw/rtl/affine_matrix_inverse_4x4_core_macros.svh -----
// Assertion helpers shared by the RTL of the 4x4 inverse core.
// Each macro expects clk_i and rst_ni in the enclosing module.
`ifndef AFFINE_MATRIX_INVERSE_4X4_CORE_MACROS_SVH
`define AFFINE_MATRIX_INVERSE_4X4_CORE_MACROS_SVH

// A condition that must hold at every clock edge outside reset.
`define AMI_ASSERT_NOW(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) else $error(msg);

// A condition that must hold in the cycle after a trigger.
`define AMI_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) else $error(msg);

`endif

// ----- hw/rtl/ami_pkg.sv -----
`default_nettype none

package ami_pkg;

  localparam int unsigned NumElem    = 16;
  localparam int unsigned IdxW       = 4;
  localparam int unsigned ElemW      = 32;
  localparam int unsigned CofW       = 64;
  localparam int unsigned NumCofOut  = 12;
  localparam int unsigned DivSteps   = 80;
  localparam int unsigned CntW       = 7;
  localparam logic [ElemW-1:0] OneQ16 = 32'h0001_0000;

  // Operand positions of the six triple products of each cofactor.
  localparam int CofTerms [16][6][3] = '{
    '{'{5,10,15},'{5,11,14},'{9,6,15},'{9,7,14},'{13,6,11},'{13,7,10}},
    '{'{1,10,15},'{1,11,14},'{9,2,15},'{9,3,14},'{13,2,11},'{13,3,10}},
    '{'{1,6,15},'{1,7,14},'{5,2,15},'{5,3,14},'{13,2,7},'{13,3,6}},
    '{'{1,6,11},'{1,7,10},'{5,2,11},'{5,3,10},'{9,2,7},'{9,3,6}},
    '{'{4,10,15},'{4,11,14},'{8,6,15},'{8,7,14},'{12,6,11},'{12,7,10}},
    '{'{0,10,15},'{0,11,14},'{8,2,15},'{8,3,14},'{12,2,11},'{12,3,10}},
    '{'{0,6,15},'{0,7,14},'{4,2,15},'{4,3,14},'{12,2,7},'{12,3,6}},
    '{'{0,6,11},'{0,7,10},'{4,2,11},'{4,3,10},'{8,2,7},'{8,3,6}},
    '{'{4,9,15},'{4,11,13},'{8,5,15},'{8,7,13},'{12,5,11},'{12,7,9}},
    '{'{0,9,15},'{0,11,13},'{8,1,15},'{8,3,13},'{12,1,11},'{12,3,9}},
    '{'{0,5,15},'{0,7,13},'{4,1,15},'{4,3,13},'{12,1,7},'{12,3,5}},
    '{'{0,5,11},'{0,7,9},'{4,1,11},'{4,3,9},'{8,1,7},'{8,3,5}},
    '{'{4,9,14},'{4,10,13},'{8,5,14},'{8,6,13},'{12,5,10},'{12,6,9}},
    '{'{0,9,14},'{0,10,13},'{8,1,14},'{8,2,13},'{12,1,10},'{12,2,9}},
    '{'{0,5,14},'{0,6,13},'{4,1,14},'{4,2,13},'{12,1,6},'{12,2,5}},
    '{'{0,5,10},'{0,6,9},'{4,1,10},'{4,2,9},'{8,1,6},'{8,2,5}}
  };

  // Term sign pattern for an even row plus column: + - - + + -.
  localparam logic [5:0] TermNegMask = 6'b100110;

  function automatic logic [IdxW-1:0] cof_operand(logic [3:0] k, logic [2:0] t,
                                                  logic [1:0] j);
    return IdxW'(CofTerms[k][t][j]);
  endfunction

  // Datapath operations issued by the controller, one per cycle.
  typedef enum logic [4:0] {
    OP_NONE, OP_ACLR, OP_LDA, OP_LDB, OP_MAB, OP_DLD, OP_MLO, OP_MHI, OP_SUM,
    OP_ACC, OP_RCOF, OP_RDET, OP_DLOAD, OP_DSTEP, OP_DFIN, OP_ZERO, OP_ONE
  } dp_op_e;

  typedef struct packed {
    dp_op_e          op;
    logic            neg;
    logic            mat_we;
    logic [IdxW-1:0] mat_addr;
    logic [IdxW-1:0] cof_addr;
  } dp_cmd_t;

  typedef struct packed {
    logic det_zero;
  } dp_stat_t;

endpackage

`default_nettype wire

// ----- hw/rtl/ami_ram.sv -----
`default_nettype none

// Simple dual-port RAM: one write port, one registered read port.
module ami_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

// ----- hw/rtl/ami_dpath.sv -----
`default_nettype none

module ami_dpath (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire ami_pkg::dp_cmd_t      cmd_i,
  input  wire logic [3:0]            elem_index_i,
  input  wire logic [31:0]           elem_value_i,
  output ami_pkg::dp_stat_t          stat_o,
  output logic [31:0]                value_o
);

  logic [31:0] mat_rdata;
  logic [63:0] cof_rdata, cof_wdata;
  logic [31:0] ra_q, rb_q, y_q;
  logic [63:0] x_q, plo_q, phi_q;
  logic        sgn_q;
  logic [95:0] prod_q;
  logic [99:0] acc_q;
  logic [63:0] det_q;
  logic [63:0] rem_q, den_q;
  logic [79:0] num_q;
  logic [31:0] quo_q, value_q;
  logic        ovf_q, qneg_q;

  logic [63:0] mab, mlo, mhi;
  logic [99:0] term_ext;
  logic [64:0] div_trial, div_diff;
  logic        div_ge;
  logic [31:0] div_sat;

  function automatic logic [31:0] abs32(logic [31:0] v);
    return v[31] ? (~v + 32'd1) : v;
  endfunction

  function automatic logic [63:0] abs64(logic [63:0] v);
    return v[63] ? (~v + 64'd1) : v;
  endfunction

  // Drop 16 fraction bits toward zero and saturate to signed 64 bits.
  function automatic logic [63:0] reduce_acc(logic [99:0] a);
    logic [99:0] mag;
    logic [83:0] s;
    logic [63:0] r;
    mag = a[99] ? (~a + 100'd1) : a;
    s   = mag[99:16];
    if (!a[99]) begin
      r = (|s[83:63]) ? 64'h7FFF_FFFF_FFFF_FFFF : s[63:0];
    end else begin
      r = (|s[83:63]) ? 64'h8000_0000_0000_0000 : (~s[63:0] + 64'd1);
    end
    return r;
  endfunction

  // Element and cofactor storage.
  ami_ram #(.Width(ami_pkg::ElemW), .Depth(ami_pkg::NumElem)) u_mat_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.mat_we),
    .waddr_i (elem_index_i),
    .wdata_i (elem_value_i),
    .raddr_i (cmd_i.mat_addr),
    .rdata_o (mat_rdata)
  );

  ami_ram #(.Width(ami_pkg::CofW), .Depth(ami_pkg::NumElem)) u_cof_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.op == ami_pkg::OP_RCOF),
    .waddr_i (cmd_i.cof_addr),
    .wdata_i (cof_wdata),
    .raddr_i (cmd_i.cof_addr),
    .rdata_o (cof_rdata)
  );

  // Three 32x32 multipliers: operand magnitudes, and the low and high halves of x_q by y_q.
  assign mab       = 64'(abs32(ra_q)) * 64'(abs32(rb_q));
  assign mlo       = 64'(x_q[31:0]) * 64'(y_q);
  assign mhi       = 64'(x_q[63:32]) * 64'(y_q);
  assign term_ext  = {4'b0, prod_q};
  assign cof_wdata = reduce_acc(acc_q);

  // One restoring division step.
  assign div_trial = {rem_q, num_q[79]};
  assign div_ge    = div_trial >= {1'b0, den_q};
  assign div_diff  = div_trial - {1'b0, den_q};

  always_comb begin
    if (qneg_q) begin
      div_sat = (ovf_q || quo_q > 32'h8000_0000) ? 32'h8000_0000 : (~quo_q + 32'd1);
    end else begin
      div_sat = (ovf_q || quo_q[31]) ? 32'h7FFF_FFFF : quo_q;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      ami_pkg::OP_ACLR: acc_q <= '0;
      ami_pkg::OP_LDA:  ra_q <= mat_rdata;
      ami_pkg::OP_LDB:  rb_q <= mat_rdata;
      ami_pkg::OP_MAB: begin
        x_q   <= mab;
        y_q   <= abs32(mat_rdata);
        sgn_q <= ra_q[31] ^ rb_q[31] ^ mat_rdata[31];
      end
      ami_pkg::OP_DLD: begin
        x_q   <= abs64(cof_rdata);
        y_q   <= abs32(mat_rdata);
        sgn_q <= cof_rdata[63] ^ mat_rdata[31];
      end
      ami_pkg::OP_MLO:  plo_q <= mlo;
      ami_pkg::OP_MHI:  phi_q <= mhi;
      ami_pkg::OP_SUM:  prod_q <= {phi_q, 32'b0} + {32'b0, plo_q};
      ami_pkg::OP_ACC: begin
        acc_q <= (sgn_q ^ cmd_i.neg) ? (acc_q - term_ext) : (acc_q + term_ext);
      end
      ami_pkg::OP_RCOF: acc_q <= '0;
      ami_pkg::OP_DLOAD: begin
        num_q  <= {abs64(cof_rdata), 16'b0};
        den_q  <= abs64(det_q);
        qneg_q <= cof_rdata[63] ^ det_q[63];
        rem_q  <= '0;
        quo_q  <= '0;
        ovf_q  <= 1'b0;
      end
      ami_pkg::OP_DSTEP: begin
        num_q <= {num_q[78:0], 1'b0};
        rem_q <= div_ge ? div_diff[63:0] : div_trial[63:0];
        ovf_q <= ovf_q | quo_q[31];
        quo_q <= {quo_q[30:0], div_ge};
      end
      ami_pkg::OP_DFIN: value_q <= div_sat;
      ami_pkg::OP_ZERO: value_q <= '0;
      ami_pkg::OP_ONE:  value_q <= ami_pkg::OneQ16;
      default: ;
    endcase
  end

  // The determinant is architectural state with a reset value.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      det_q <= '0;
    end else if (cmd_i.op == ami_pkg::OP_RDET) begin
      det_q <= reduce_acc(acc_q);
    end
  end

  assign stat_o.det_zero = (det_q == 64'd0);
  assign value_o         = value_q;

endmodule

`default_nettype wire

// ----- hw/rtl/ami_ctrl.sv -----
`default_nettype none

module ami_ctrl (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  input  wire logic             compute_i,
  output logic                  in_ready_o,
  output logic                  out_valid_o,
  input  wire logic             out_ready_i,
  output logic [3:0]            out_index_o,
  output logic                  singular_o,
  output logic                  out_last_o,
  output ami_pkg::dp_cmd_t      cmd_o,
  input  wire ami_pkg::dp_stat_t stat_i
);

  typedef enum logic [18:0] {
    S_IDLE = 19'd1,     S_RA   = 19'd2,     S_RB   = 19'd4,     S_RC  = 19'd8,
    S_MAB  = 19'd16,    S_DRD  = 19'd32,    S_DLD  = 19'd64,    S_MLO = 19'd128,
    S_MHI  = 19'd256,   S_SUM  = 19'd512,   S_ACC  = 19'd1024,  S_RCOF = 19'd2048,
    S_RDET = 19'd4096,  S_CHK  = 19'd8192,  S_ORD  = 19'd16384, S_OLD = 19'd32768,
    S_DIV  = 19'd65536, S_DFIN = 19'd131072, S_OUT = 19'd262144
  } ctrl_state_e;

  ctrl_state_e                  state_q, state_d;
  logic [3:0]                   k_q, k_d;
  logic [2:0]                   t_q, t_d;
  logic [ami_pkg::CntW-1:0]     cnt_q, cnt_d;
  logic                         det_mode_q, det_mode_d;
  logic                         sing_q, sing_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      k_q        <= '0;
      t_q        <= '0;
      cnt_q      <= '0;
      det_mode_q <= 1'b0;
      sing_q     <= 1'b0;
    end else begin
      state_q    <= state_d;
      k_q        <= k_d;
      t_q        <= t_d;
      cnt_q      <= cnt_d;
      det_mode_q <= det_mode_d;
      sing_q     <= sing_d;
    end
  end

  // Sequencer: cofactor terms, determinant terms, then one division per output up to index 11.
  always_comb begin
    state_d        = state_q;
    k_d            = k_q;
    t_d            = t_q;
    cnt_d          = cnt_q;
    det_mode_d     = det_mode_q;
    sing_d         = sing_q;
    cmd_o.op       = ami_pkg::OP_NONE;
    cmd_o.neg      = 1'b0;
    cmd_o.mat_we   = 1'b0;
    cmd_o.mat_addr = '0;
    cmd_o.cof_addr = k_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.mat_we = 1'b1;
          if (compute_i) begin
            cmd_o.op   = ami_pkg::OP_ACLR;
            k_d        = '0;
            t_d        = '0;
            det_mode_d = 1'b0;
            state_d    = S_RA;
          end
        end
      end
      S_RA: begin
        cmd_o.mat_addr = ami_pkg::cof_operand(k_q, t_q, 2'd0);
        state_d        = S_RB;
      end
      S_RB: begin
        cmd_o.mat_addr = ami_pkg::cof_operand(k_q, t_q, 2'd1);
        cmd_o.op       = ami_pkg::OP_LDA;
        state_d        = S_RC;
      end
      S_RC: begin
        cmd_o.mat_addr = ami_pkg::cof_operand(k_q, t_q, 2'd2);
        cmd_o.op       = ami_pkg::OP_LDB;
        state_d        = S_MAB;
      end
      S_MAB: begin
        cmd_o.op = ami_pkg::OP_MAB;
        state_d  = S_MLO;
      end
      S_DRD: begin
        cmd_o.mat_addr = {2'b00, t_q[1:0]};
        cmd_o.cof_addr = {t_q[1:0], 2'b00};
        state_d        = S_DLD;
      end
      S_DLD: begin
        cmd_o.op = ami_pkg::OP_DLD;
        state_d  = S_MLO;
      end
      S_MLO: begin
        cmd_o.op = ami_pkg::OP_MLO;
        state_d  = S_MHI;
      end
      S_MHI: begin
        cmd_o.op = ami_pkg::OP_MHI;
        state_d  = S_SUM;
      end
      S_SUM: begin
        cmd_o.op = ami_pkg::OP_SUM;
        state_d  = S_ACC;
      end
      S_ACC: begin
        cmd_o.op = ami_pkg::OP_ACC;
        if (det_mode_q) begin
          if (t_q == 3'd3) begin
            state_d = S_RDET;
          end else begin
            t_d     = t_q + 3'd1;
            state_d = S_DRD;
          end
        end else begin
          cmd_o.neg = ami_pkg::TermNegMask[t_q] ^ k_q[2] ^ k_q[0];
          if (t_q == 3'd5) begin
            state_d = S_RCOF;
          end else begin
            t_d     = t_q + 3'd1;
            state_d = S_RA;
          end
        end
      end
      S_RCOF: begin
        cmd_o.op = ami_pkg::OP_RCOF;
        t_d      = '0;
        if (k_q == 4'd15) begin
          det_mode_d = 1'b1;
          state_d    = S_DRD;
        end else begin
          k_d     = k_q + 4'd1;
          state_d = S_RA;
        end
      end
      S_RDET: begin
        cmd_o.op = ami_pkg::OP_RDET;
        state_d  = S_CHK;
      end
      S_CHK: begin
        k_d = '0;
        if (stat_i.det_zero) begin
          sing_d   = 1'b1;
          cmd_o.op = ami_pkg::OP_ZERO;
          state_d  = S_OUT;
        end else begin
          sing_d  = 1'b0;
          state_d = S_ORD;
        end
      end
      S_ORD: begin
        state_d = S_OLD;
      end
      S_OLD: begin
        cmd_o.op = ami_pkg::OP_DLOAD;
        cnt_d    = ami_pkg::CntW'(ami_pkg::DivSteps - 1);
        state_d  = S_DIV;
      end
      S_DIV: begin
        cmd_o.op = ami_pkg::OP_DSTEP;
        if (cnt_q == '0) begin
          state_d = S_DFIN;
        end else begin
          cnt_d = cnt_q - 1'b1;
        end
      end
      S_DFIN: begin
        cmd_o.op = ami_pkg::OP_DFIN;
        state_d  = S_OUT;
      end
      S_OUT: begin
        if (out_ready_i) begin
          if (sing_q || k_q == 4'd15) begin
            state_d = S_IDLE;
          end else begin
            k_d = k_q + 4'd1;
            if (k_q < 4'(ami_pkg::NumCofOut - 1)) begin
              state_d = S_ORD;
            end else begin
              cmd_o.op = (k_q == 4'd14) ? ami_pkg::OP_ONE : ami_pkg::OP_ZERO;
            end
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = (state_q == S_OUT);
  assign out_index_o = k_q;
  assign singular_o  = sing_q;
  assign out_last_o  = sing_q || (k_q == 4'd15);

endmodule

`default_nettype wire

// ----- hw/rtl/affine_matrix_inverse_4x4_core.sv -----
// 4x4 affine matrix inverse, signed Q16.16, by cofactors and adjugate.
// Input channel: one beat writes elem_value_i at row-major elem_index_i; a beat
// with compute_i set stores its element and then inverts the stored matrix.
// Output channel: sixteen beats, out_index_o 0 to 15 in order, each a saturated
// quotient rounded toward zero; the last row is 0, 0, 0, 1.0 and out_last_o
// marks index 15. A zero determinant gives a single beat with singular_o and
// out_last_o set, index and value zero.
// A compute beat runs 16 cofactors at 6 terms each (three element reads, an
// operand product, low and high partial products, a sum and an accumulate)
// plus a reduce step, then 4 determinant terms plus a reduce step and a zero
// check, then per quotient two cofactor read states, an 80-step restoring
// division at one quotient bit per cycle, a saturation state and an output
// state; the four affine results are constants. The 32x32 multipliers of the
// one product pipeline and the serial divider set the pace of this sequence.
// The input channel is ready only while no inversion is in progress.
// A stalled receiver holds the current result and the sequencer waits.
// Reset returns the controller to idle and clears the determinant; matrix and
// cofactor storage hold no defined values until written.
`default_nettype none
`include "affine_matrix_inverse_4x4_core_macros.svh"

module affine_matrix_inverse_4x4_core (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [3:0]  elem_index_i,
  input  wire logic [31:0] elem_value_i,
  input  wire logic        compute_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [3:0]       out_index_o,
  output logic [31:0]      out_value_o,
  output logic             singular_o,
  output logic             out_last_o
);

  ami_pkg::dp_cmd_t  cmd;
  ami_pkg::dp_stat_t stat;

  ami_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .compute_i   (compute_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_index_o (out_index_o),
    .singular_o  (singular_o),
    .out_last_o  (out_last_o),
    .cmd_o       (cmd),
    .stat_i      (stat)
  );

  ami_dpath u_dpath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .elem_index_i (elem_index_i),
    .elem_value_i (elem_value_i),
    .stat_o       (stat),
    .value_o      (out_value_o)
  );

  // The sequencer never takes a beat while a result is pending.
  `AMI_ASSERT_NOW(a_no_overlap, !(out_valid_o && in_ready_o), "input ready during output")
  // A singular result is the only and last beat, at index zero.
  `AMI_ASSERT_NOW(a_singular_form, !(out_valid_o && singular_o) || (out_last_o && out_index_o == 4'd0), "bad singular beat")
  // Delivering the last beat returns the block to idle.
  `AMI_ASSERT_NEXT(a_last_idle, out_valid_o && out_ready_i && out_last_o, in_ready_o && !out_valid_o, "not idle after last")
  // A load beat leaves the block ready for the next one.
  `AMI_ASSERT_NEXT(a_load_idle, in_valid_i && in_ready_o && !compute_i, in_ready_o, "load left idle")

endmodule

`default_nettype wire

// ----- bench/inverse_checker.sv -----
`timescale 1ns / 100ps

module inverse_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  logic [3:0]  elem_index_i,
  input  logic [31:0] elem_value_i,
  input  logic        compute_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  logic [3:0]  out_index_i,
  input  logic [31:0] out_value_i,
  input  logic        singular_i,
  input  logic        out_last_i,
  output int          fail_count_o,
  output int          pending_o,
  output int          singular_seen_o
);

  typedef struct {
    logic [3:0]  idx;
    logic [31:0] val;
    logic        sing;
    logic        last;
  } inv_beat_t;

  localparam logic signed [127:0] S64Max = 128'sh7FFF_FFFF_FFFF_FFFF;
  localparam logic signed [127:0] S64Min = -128'sh8000_0000_0000_0000;

  logic signed [31:0] elems [16];
  logic signed [63:0] cofs [16];
  logic signed [63:0] det_q32;
  inv_beat_t          inverse_q [$];

  assign pending_o = inverse_q.size();

  // Element at (row, col) widened so every product below stays exact.
  function automatic logic signed [127:0] at(int r, int c);
    logic signed [127:0] w;
    w = elems[r * 4 + c];
    return w;
  endfunction

  // Drop sixteen fraction bits toward zero and saturate to 64 bits.
  function automatic logic signed [63:0] cut_q32(logic signed [127:0] x);
    logic signed [127:0] m;
    logic signed [127:0] nm;
    m = (x < 0) ? -x : x;
    m = m >>> 16;
    nm = -m;
    if (x >= 0) return (m > S64Max) ? S64Max[63:0] : m[63:0];
    return (m > -S64Min) ? S64Min[63:0] : nm[63:0];
  endfunction

  // Signed minor with one row and one column removed, exact.
  function automatic logic signed [127:0] minor3(int skip_r, int skip_c);
    int rr [3];
    int cc [3];
    int nr;
    int nc;
    nr = 0;
    nc = 0;
    for (int i = 0; i < 4; i++) begin
      if (i != skip_r) begin
        rr[nr] = i;
        nr++;
      end
      if (i != skip_c) begin
        cc[nc] = i;
        nc++;
      end
    end
    return at(rr[0], cc[0]) * (at(rr[1], cc[1]) * at(rr[2], cc[2])
                             - at(rr[1], cc[2]) * at(rr[2], cc[1]))
         - at(rr[0], cc[1]) * (at(rr[1], cc[0]) * at(rr[2], cc[2])
                             - at(rr[1], cc[2]) * at(rr[2], cc[0]))
         + at(rr[0], cc[2]) * (at(rr[1], cc[0]) * at(rr[2], cc[1])
                             - at(rr[1], cc[1]) * at(rr[2], cc[0]));
  endfunction

  // Quotient num * 2^16 / den toward zero, saturated to Q16.16.
  function automatic logic [31:0] q16_quot(logic signed [63:0] num,
                                           logic signed [63:0] den);
    logic signed [127:0] n;
    logic signed [127:0] d;
    logic [127:0]        q;
    n = num;
    d = den;
    if (n < 0) n = -n;
    if (d < 0) d = -d;
    q = (n <<< 16) / d;
    if ((num < 0) != (den < 0)) return (q > 128'h8000_0000) ? 32'h8000_0000 : -q[31:0];
    return (q > 128'h7FFF_FFFF) ? 32'h7FFF_FFFF : q[31:0];
  endfunction

  // Adjugate divided by the determinant, with the affine last row, or one singular beat.
  task automatic predict_inverse();
    logic signed [127:0] acc;
    inv_beat_t           b;
    for (int k = 0; k < 16; k++) begin
      acc = minor3(k % 4, k / 4);
      if (((k / 4) + (k % 4)) % 2 == 1) acc = -acc;
      cofs[k] = cut_q32(acc);
    end
    acc = 0;
    for (int t = 0; t < 4; t++) acc += at(0, t) * $signed({{64{cofs[t * 4][63]}}, cofs[t * 4]});
    det_q32 = cut_q32(acc);
    if (det_q32 == 0) begin
      b = '{idx: 4'd0, val: 32'd0, sing: 1'b1, last: 1'b1};
      inverse_q.push_back(b);
    end else begin
      for (int k = 0; k < 16; k++) begin
        b.idx  = 4'(k);
        b.sing = 1'b0;
        b.last = (k == 15);
        if (k < 12) b.val = q16_quot(cofs[k], det_q32);
        else b.val = (k == 15) ? 32'h0001_0000 : 32'd0;
        inverse_q.push_back(b);
      end
    end
  endtask

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("[%0t] mismatch on %s: got 0x%0h, expected 0x%0h", $realtime, what, got, want);
    fail_count_o++;
  endtask

  // Watch both channels and compare each result beat with the oldest prediction.
  always @(posedge clk_i or negedge rst_ni) begin
    inv_beat_t want;
    if (!rst_ni) begin
      fail_count_o    <= 0;
      singular_seen_o <= 0;
      det_q32         <= '0;
    end else begin
      if (in_valid_i && in_ready_i) begin
        elems[elem_index_i] = elem_value_i;
        if (compute_i) predict_inverse();
      end
      if (out_valid_i && out_ready_i) begin
        if (inverse_q.size() == 0) begin
          $display("[%0t] result beat with nothing expected", $realtime);
          fail_count_o++;
        end else begin
          want = inverse_q.pop_front();
          if (out_index_i !== want.idx) report_mismatch("out_index", out_index_i, want.idx);
          if (out_value_i !== want.val) report_mismatch("out_value", out_value_i, want.val);
          if (singular_i !== want.sing) report_mismatch("singular", singular_i, want.sing);
          if (out_last_i !== want.last) report_mismatch("out_last", out_last_i, want.last);
          if (singular_i === 1'b1) singular_seen_o++;
        end
      end
    end
  end

endmodule

// ----- bench/tb.sv -----
`timescale 1ns / 100ps

module tb;

  localparam int StallLimit = 20000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [3:0]  elem_index_i = '0;
  logic [31:0] elem_value_i = '0;
  logic        compute_i = 1'b0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [3:0]  out_index_o;
  logic [31:0] out_value_o;
  logic        singular_o;
  logic        out_last_o;

  int fail_count;
  int pending;
  int singular_seen;
  int send_idle_pct;
  int recv_stall_pct;
  int beats_sent;
  int inversions;
  int quiet_cycles;

  affine_matrix_inverse_4x4_core DUT (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .elem_index_i, .elem_value_i,
    .compute_i, .out_valid_o, .out_ready_i, .out_index_o, .out_value_o,
    .singular_o, .out_last_o
  );

  inverse_checker checker_i (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_i(in_ready_o), .elem_index_i,
    .elem_value_i, .compute_i, .out_valid_i(out_valid_o), .out_ready_i,
    .out_index_i(out_index_o), .out_value_i(out_value_o), .singular_i(singular_o),
    .out_last_i(out_last_o), .fail_count_o(fail_count), .pending_o(pending),
    .singular_seen_o(singular_seen)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Receiver stalls at random according to the current phase.
  always @(posedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Give up when no beat moves on either channel for too long.
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= StallLimit) begin
      $display("Timeout: no beat moved for %0d cycles", StallLimit);
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // One input beat; valid drops only when the sender decides to idle.
  task automatic send_elem(logic [3:0] idx, logic [31:0] val, logic comp);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
      while ($urandom_range(99) < send_idle_pct) @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    elem_index_i <= idx;
    elem_value_i <= val;
    compute_i    <= comp;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    beats_sent++;
    if (comp) inversions++;
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  // Random Q16.16 value: mostly modest numbers, some raw words and edges.
  function automatic logic [31:0] pick_value();
    int sel;
    sel = $urandom_range(99);
    if (sel < 60) return 32'($signed($urandom_range(8 << 16)) - (4 << 16));
    if (sel < 80) return $urandom;
    if (sel < 90) return 32'd0;
    return ($urandom_range(1)) ? 32'h7FFF_FFFF : 32'h8000_0000;
  endfunction

  initial begin
    int nwrites;
    quiet_cycles   = 0;
    beats_sent     = 0;
    inversions     = 0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: identity, then singular, saturating and extreme elements.
    for (int i = 0; i < 16; i++)
      send_elem(4'(i), (i % 5 == 0) ? 32'h0001_0000 : 32'd0, i == 15);
    send_elem(4'd0, 32'd0, 1'b1);
    send_elem(4'd0, 32'd1, 1'b1);
    send_elem(4'd0, 32'h0001_0000, 1'b0);
    send_elem(4'd10, 32'hFFFF_0000, 1'b1);
    send_elem(4'd15, 32'h7FFF_FFFF, 1'b1);
    send_elem(4'd5, 32'h8000_0000, 1'b1);
    wait_drained();
    send_elem(4'd7, 32'hFFFF_FFFF, 1'b1);

    // Random matrices: zero, one or sixteen element updates, then an inversion.
    for (int r = 0; r < 28; r++) begin
      case (r / 7)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 65; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 65; end
        default: begin send_idle_pct = 11; recv_stall_pct = 11; end
      endcase
      if (r == 10) wait_drained();
      nwrites = (r % 9 == 4) ? 16 : $urandom_range(1);
      for (int w = 0; w < nwrites; w++) send_elem(4'($urandom_range(15)), pick_value(), 1'b0);
      send_elem(4'($urandom_range(15)), pick_value(), 1'b1);
    end

    wait_drained();
    repeat (20) @(posedge clk_i);
    $display("Covered %0d input beats and %0d inversions, %0d of them singular,",
             beats_sent, inversions, singular_seen);
    $display("under free-running, idle-sender, stalled-receiver and mixed flow control.");
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+hw/rtl
hw/rtl/ami_pkg.sv
hw/rtl/ami_ram.sv
hw/rtl/ami_dpath.sv
hw/rtl/ami_ctrl.sv
hw/rtl/affine_matrix_inverse_4x4_core.sv
bench/inverse_checker.sv
bench/tb.sv
